// ===== rtl/lsq_pkg.sv =====
// shared constants, codes and types of the least squares line fit core
// no dependencies; compiled first
package lsq_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 22;
	localparam int FRAC_BITS      = 16;
	localparam int OUT_W          = 32;

	typedef logic [1:0] fit_status_t;

	localparam fit_status_t ST_OK    = 2'd0;
	localparam fit_status_t ST_DEGEN = 2'd1;
	localparam fit_status_t ST_DROP  = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/lsq_if.sv =====
// point request and fit result channels of the least squares line fit core
// depends on lsq_pkg
interface lsq_pt_if #(
	parameter int COORD_BITS = lsq_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] x_pos;
	logic signed [COORD_BITS-1:0] y_pos;
	logic signed [COORD_BITS-1:0] z_pos;
	logic                         fit_xy_plane;
	logic                         last_point;

	modport source(output valid, x_pos, y_pos, z_pos, fit_xy_plane, last_point, input ready);
	modport sink(input valid, x_pos, y_pos, z_pos, fit_xy_plane, last_point, output ready);
endinterface

interface lsq_res_if;
	logic                             valid;
	logic                             ready;
	logic signed [lsq_pkg::OUT_W-1:0] slope;
	logic signed [lsq_pkg::OUT_W-1:0] intercept;
	logic                             plane_echo;
	lsq_pkg::fit_status_t             fit_status;

	modport source(output valid, slope, intercept, plane_echo, fit_status, input ready);
	modport sink(input valid, slope, intercept, plane_echo, fit_status, output ready);
endinterface

// ===== rtl/least_squares_line_fit_core.sv =====
// least squares line fit core: top level, sequencer and shared datapath
// depends on lsq_pkg, lsq_if, lsq_store and lsq_div
//
// usage
//   point channel: one request per 3d point. fit_xy_plane is sampled on the
//   first point of a set (1 fits y on x, 0 fits z on x). last_point closes
//   the set and starts the fit. points beyond MAX_POINTS are dropped and
//   flagged in fit_status unless the fit is degenerate.
//   result channel: one request per set with slope (Q16.16), intercept,
//   plane_echo and fit_status (ok, degenerate, points dropped).
//   a non-last point is accepted and ready stays high. after the last
//   point ready is low while the fit runs: two divisions for the means and,
//   unless the fit is degenerate, one for the slope on one shared restoring
//   divider of DIV_W = 2*COORD_BITS + clog2(MAX_POINTS) + 19 bits (one bit
//   per cycle), plus a walk over the stored points on the one shared multiplier.
//   the result sits in an output register; a stalled receiver only holds
//   the sequencer at its final step, points of the next set are taken once
//   the result is loaded. reset empties the set and the output register;
//   store contents need no clearing since only entries of the current set
//   are read.
module least_squares_line_fit_core #(
	parameter int MAX_POINTS = lsq_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = lsq_pkg::COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lsq_pt_if.sink    point,
	lsq_res_if.source result
);
	import lsq_pkg::*;

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int SUM_W  = COORD_BITS + IDX_W + 1;
	localparam int DX_W   = COORD_BITS + 1;
	localparam int ACC_W  = 2 * COORD_BITS + IDX_W + 3;
	localparam int DIV_W  = ACC_W + FRAC_BITS;
	localparam int MUL_W  = (DX_W > OUT_W) ? DX_W : OUT_W;
	localparam int PROD_W = 2 * MUL_W;
	// intercept difference, then its integer part after dropping the fraction
	localparam int IW     = COORD_BITS + OUT_W + 1;
	localparam int TW     = IW - FRAC_BITS;
	localparam int EW     = (TW > OUT_W) ? TW : OUT_W + 1;

	localparam logic signed [EW-1:0] ICPT_MAX = {{(EW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [EW-1:0] ICPT_MIN = {{(EW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
	localparam logic [OUT_W-1:0]     SL_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0]     SL_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_MX_GO   = 4'd1;
	localparam logic [3:0] S_MX_WAIT = 4'd2;
	localparam logic [3:0] S_MD_GO   = 4'd3;
	localparam logic [3:0] S_MD_WAIT = 4'd4;
	localparam logic [3:0] S_RD      = 4'd5;
	localparam logic [3:0] S_MND     = 4'd6;
	localparam logic [3:0] S_MDD     = 4'd7;
	localparam logic [3:0] S_ACC     = 4'd8;
	localparam logic [3:0] S_SL_GO   = 4'd9;
	localparam logic [3:0] S_SL_WAIT = 4'd10;
	localparam logic [3:0] S_MULI    = 4'd11;
	localparam logic [3:0] S_ICPT    = 4'd12;
	localparam logic [3:0] S_OUT     = 4'd13;

	logic [3:0]                   state_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             walk_q;
	logic signed [SUM_W-1:0]      sum_x_q;
	logic signed [SUM_W-1:0]      sum_d_q;
	logic                         plane_q;
	logic                         ovf_q;
	logic signed [COORD_BITS-1:0] mx_q;
	logic signed [COORD_BITS-1:0] md_q;
	logic signed [ACC_W-1:0]      num_q;
	logic signed [ACC_W-1:0]      den_q;
	logic signed [PROD_W-1:0]     prod_q;
	logic signed [OUT_W-1:0]      slope_q;
	logic signed [OUT_W-1:0]      icpt_q;
	fit_status_t                  status_q;

	// output register
	logic                    res_valid_q;
	logic signed [OUT_W-1:0] out_slope_q;
	logic signed [OUT_W-1:0] out_icpt_q;
	logic                    out_plane_q;
	fit_status_t             out_status_q;

	logic                         accept;
	logic                         plane_eff;
	logic signed [COORD_BITS-1:0] dep_in;
	logic                         st_wr_en;
	logic [2*COORD_BITS-1:0]      rd_data;
	logic signed [COORD_BITS-1:0] rd_x;
	logic signed [COORD_BITS-1:0] rd_d;
	logic signed [DX_W-1:0]       dx;
	logic signed [DX_W-1:0]       dd;
	logic signed [MUL_W-1:0]      mul_a;
	logic signed [MUL_W-1:0]      mul_b;
	logic signed [ACC_W-1:0]      prod_acc;
	logic [SUM_W-1:0]             sum_x_abs;
	logic [SUM_W-1:0]             sum_d_abs;
	logic [ACC_W-1:0]             num_abs;
	logic                         div_start;
	logic [DIV_W-1:0]             div_a;
	logic [DIV_W-1:0]             div_b;
	logic [DIV_W-1:0]             div_quo;
	div_stat_t                    div_stat;
	logic [COORD_BITS-1:0]        mean_mag;
	logic [OUT_W-1:0]             q_lo;
	logic                         q_big;
	logic signed [OUT_W-1:0]      slope_sat;
	logic signed [IW-1:0]         prod_lo;
	logic signed [IW-1:0]         icpt_v;
	logic signed [TW-1:0]         icpt_t;
	logic signed [EW-1:0]         icpt_e;
	logic signed [OUT_W-1:0]      icpt_sat;
	logic                         walk_last;

	// point intake
	always_comb begin
		accept    = point.valid && point.ready;
		plane_eff = (count_q == '0) ? point.fit_xy_plane : plane_q;
		dep_in    = plane_eff ? point.y_pos : point.z_pos;
		st_wr_en  = accept && (count_q < CNT_W'(MAX_POINTS));
	end

	assign point.ready = (state_q == S_IDLE);

	lsq_store #(
		.DEPTH(MAX_POINTS),
		.WIDTH(2 * COORD_BITS)
	) u_store (
		.clk    (clk),
		.wr_en  (st_wr_en),
		.wr_addr(count_q[IDX_W-1:0]),
		.wr_data({point.x_pos, dep_in}),
		.rd_addr(walk_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	// centred terms and the shared multiplier operand select
	always_comb begin
		rd_x      = rd_data[2*COORD_BITS-1:COORD_BITS];
		rd_d      = rd_data[COORD_BITS-1:0];
		dx        = DX_W'(rd_x) - DX_W'(mx_q);
		dd        = DX_W'(rd_d) - DX_W'(md_q);
		prod_acc  = ACC_W'(signed'(prod_q[2*DX_W-1:0]));
		walk_last = (walk_q + 1'b1) == count_q;
		case (state_q)
			S_MND: begin
				mul_a = MUL_W'(dx);
				mul_b = MUL_W'(dd);
			end
			S_MDD: begin
				mul_a = MUL_W'(dx);
				mul_b = MUL_W'(dx);
			end
			default: begin
				// slope times mean x for the intercept
				mul_a = MUL_W'(slope_q);
				mul_b = MUL_W'(mx_q);
			end
		endcase
	end

	// shared divider operands: means use magnitudes over the count,
	// the slope uses |num| scaled by 2^16 over den
	always_comb begin
		sum_x_abs = sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
		sum_d_abs = sum_d_q[SUM_W-1] ? SUM_W'(-sum_d_q) : SUM_W'(sum_d_q);
		num_abs   = num_q[ACC_W-1] ? ACC_W'(-num_q) : ACC_W'(num_q);
		div_start = (state_q == S_MX_GO) || (state_q == S_MD_GO) ||
		            ((state_q == S_SL_GO) && (den_q != '0));
		case (state_q)
			S_MX_GO: begin
				div_a = DIV_W'(sum_x_abs);
				div_b = DIV_W'(count_q);
			end
			S_MD_GO: begin
				div_a = DIV_W'(sum_d_abs);
				div_b = DIV_W'(count_q);
			end
			default: begin
				div_a = {num_abs, {FRAC_BITS{1'b0}}};
				div_b = {{FRAC_BITS{1'b0}}, den_q};
			end
		endcase
	end

	lsq_div #(
		.W(DIV_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_a),
		.divisor (div_b),
		.stat    (div_stat),
		.quotient(div_quo)
	);

	// quotient post-processing: mean magnitude and saturated slope
	always_comb begin
		mean_mag = div_quo[COORD_BITS-1:0];
		q_lo     = div_quo[OUT_W-1:0];
		q_big    = |div_quo[DIV_W-1:OUT_W];
		if (num_q[ACC_W-1]) begin
			slope_sat = (q_big || (q_lo > SL_MIN)) ? SL_MIN : -q_lo;
		end else begin
			slope_sat = (q_big || q_lo[OUT_W-1]) ? SL_MAX : q_lo;
		end
	end

	// intercept: (md*2^16 - slope*mx) / 2^16 toward zero, then saturate
	always_comb begin
		prod_lo = prod_q[IW-1:0];
		icpt_v  = (IW'(md_q) <<< FRAC_BITS) - prod_lo;
		icpt_t  = icpt_v[IW-1:FRAC_BITS];
		if (icpt_v[IW-1] && (icpt_v[FRAC_BITS-1:0] != '0)) begin
			icpt_t = icpt_t + 1'b1;
		end
		icpt_e = EW'(icpt_t);
		if (icpt_e > ICPT_MAX) begin
			icpt_sat = SL_MAX;
		end else if (icpt_e < ICPT_MIN) begin
			icpt_sat = SL_MIN;
		end else begin
			icpt_sat = icpt_e[OUT_W-1:0];
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_MX_WAIT: begin
				if (div_stat.done) begin
					mx_q <= sum_x_q[SUM_W-1] ? -mean_mag : mean_mag;
				end
			end
			S_MD_WAIT: begin
				if (div_stat.done) begin
					md_q  <= sum_d_q[SUM_W-1] ? -mean_mag : mean_mag;
					num_q <= '0;
					den_q <= '0;
				end
			end
			S_MDD: begin
				num_q <= num_q + prod_acc;
			end
			S_ACC: begin
				den_q <= den_q + prod_acc;
			end
			S_SL_GO: begin
				if (den_q == '0) begin
					slope_q  <= '0;
					icpt_q   <= '0;
					status_q <= ST_DEGEN;
				end
			end
			S_SL_WAIT: begin
				if (div_stat.done) begin
					slope_q <= slope_sat;
				end
			end
			S_ICPT: begin
				icpt_q   <= icpt_sat;
				status_q <= ovf_q ? ST_DROP : ST_OK;
			end
			default: begin
			end
		endcase
		if ((state_q == S_OUT) && (!res_valid_q || result.ready)) begin
			out_slope_q  <= slope_q;
			out_icpt_q   <= icpt_q;
			out_plane_q  <= plane_q;
			out_status_q <= status_q;
		end
	end

	// sequencer and set bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			walk_q      <= '0;
			sum_x_q     <= '0;
			sum_d_q     <= '0;
			plane_q     <= 1'b0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// output register: load a new result or drain the taken one
			if ((state_q == S_OUT) && (!res_valid_q || result.ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (count_q == '0) begin
							plane_q <= point.fit_xy_plane;
						end
						if (st_wr_en) begin
							sum_x_q <= sum_x_q + SUM_W'(point.x_pos);
							sum_d_q <= sum_d_q + SUM_W'(dep_in);
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (point.last_point) begin
							state_q <= S_MX_GO;
						end
					end
				end
				S_MX_GO: begin
					state_q <= S_MX_WAIT;
				end
				S_MX_WAIT: begin
					if (div_stat.done) begin
						state_q <= S_MD_GO;
					end
				end
				S_MD_GO: begin
					state_q <= S_MD_WAIT;
				end
				S_MD_WAIT: begin
					if (div_stat.done) begin
						walk_q  <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_MND;
				end
				S_MND: begin
					state_q <= S_MDD;
				end
				S_MDD: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					walk_q  <= walk_q + 1'b1;
					state_q <= walk_last ? S_SL_GO : S_RD;
				end
				S_SL_GO: begin
					state_q <= (den_q == '0) ? S_OUT : S_SL_WAIT;
				end
				S_SL_WAIT: begin
					if (div_stat.done) begin
						state_q <= S_MULI;
					end
				end
				S_MULI: begin
					state_q <= S_ICPT;
				end
				S_ICPT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!res_valid_q || result.ready) begin
						count_q <= '0;
						sum_x_q <= '0;
						sum_d_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid      = res_valid_q;
	assign result.slope      = out_slope_q;
	assign result.intercept  = out_icpt_q;
	assign result.plane_echo = out_plane_q;
	assign result.fit_status = out_status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond store depth");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_MND || state_q == S_MDD || state_q == S_ACC)
		|-> walk_q < count_q)
		else $error("walk reads an entry not written in this set");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.fit_status == ST_DEGEN)
		|-> (result.slope == '0 && result.intercept == '0))
		else $error("degenerate fit with nonzero slope or intercept");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(point.valid && point.ready && point.last_point) |=> !point.ready)
		else $error("point taken while fit runs");
`endif

endmodule

// ===== rtl/lsq_store.sv =====
// point store: one write port, one read port with registered read data
// no dependencies
module lsq_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 44
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/lsq_div.sv =====
// shared unsigned restoring divider, one quotient bit per cycle
// depends on lsq_pkg
module lsq_div #(
	parameter int W = 68
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [W-1:0]       dividend,
	input  logic [W-1:0]       divisor,
	output lsq_pkg::div_stat_t stat,
	output logic [W-1:0]       quotient
);
	import lsq_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;
	logic          ge;

	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			// done pulses for one cycle after the last quotient bit
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				cnt_q  <= CW'(W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
